// ===== hdl/particle_kick_drift_turn_top_assert.svh =====
// Assertion macros for the particle turn pipeline.
// Both expect clk and rst_n in scope.
`ifndef PARTICLE_KICK_DRIFT_TURN_TOP_ASSERT_SVH
`define PARTICLE_KICK_DRIFT_TURN_TOP_ASSERT_SVH

// same-cycle implication
`define PKDT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PKDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pkdt_pkg.sv =====
package pkdt_pkg;

    // field widths
    localparam int PHASE_W    = 32;
    localparam int ENERGY_W   = 48;
    localparam int HRATIO_W   = 16;
    localparam int DRIFT_W    = 32;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int ANG_W      = 38;
    localparam int KICK_W     = 51;

    // pipeline depths
    localparam int DRIFT_LAT = 4;
    localparam int SINE_LAT  = 24;
    localparam int KICK_LAT  = SINE_LAT + 6;
    localparam int PIPE_LAT  = DRIFT_LAT + KICK_LAT + 1 + DRIFT_LAT;

    // register map
    typedef enum logic [REG_IDX_W-1:0] {
        REG_RF_AMP_MAIN,
        REG_RF_AMP_SECOND,
        REG_SYNC_PHASE,
        REG_HARM_SHIFT,
        REG_HARM_RATIO,
        REG_ENERGY_GAIN,
        REG_DRIFT_FACTOR,
        REG_DIRECTION
    } reg_idx_t;

    typedef struct packed {
        logic signed [ENERGY_W-1:0] rf_amp_main;
        logic signed [ENERGY_W-1:0] rf_amp_second;
        logic signed [PHASE_W-1:0]  sync_phase;
        logic signed [PHASE_W-1:0]  harmonic_phase_shift;
        logic        [HRATIO_W-1:0] harmonic_ratio;
        logic signed [ENERGY_W-1:0] energy_gain;
        logic signed [DRIFT_W-1:0]  drift_factor;
        logic                       direction;
    } cfg_t;

    // particle travelling down the pipeline
    typedef struct packed {
        logic signed [PHASE_W-1:0]  phase;
        logic signed [ENERGY_W-1:0] energy;
        logic                       last;
        logic                       clip;
    } item_t;

    // angle constants, Q.28
    localparam logic [30:0] PI_Q28      = 31'd843314857;
    localparam logic [30:0] TWO_PI_Q28  = 31'd1686629713;
    localparam logic [30:0] HALF_PI_Q28 = 31'd421657428;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;
    // 2pi * 2^7, makes any reachable angle non-negative
    localparam logic [ANG_W:0] ANG_OFFSET = 39'd215888603264;

    // Taylor divisors and their 2^32 reciprocals
    localparam int TAYLOR_N = 6;
    localparam logic [63:0] RECIP_BASE = 64'd4294967296;
    localparam logic [7:0] TAYLOR_DIV [TAYLOR_N] =
        '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [29:0] TAYLOR_RECIP [TAYLOR_N] = '{
        30'(RECIP_BASE / 64'd156), 30'(RECIP_BASE / 64'd110), 30'(RECIP_BASE / 64'd72),
        30'(RECIP_BASE / 64'd42),  30'(RECIP_BASE / 64'd20),  30'(RECIP_BASE / 64'd6)
    };

endpackage

// ===== hdl/pkdt_in_if.sv =====
interface pkdt_in_if
    import pkdt_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [PHASE_W-1:0]  phase_in;
    logic signed [ENERGY_W-1:0] energy_in;
    logic                       last_in;

    modport source (output valid, phase_in, energy_in, last_in, input ready);
    modport sink   (input valid, phase_in, energy_in, last_in, output ready);
endinterface

// ===== hdl/pkdt_out_if.sv =====
interface pkdt_out_if
    import pkdt_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [PHASE_W-1:0]  phase_out;
    logic signed [ENERGY_W-1:0] energy_out;
    logic                       last_out;
    logic                       saturated;

    modport source (output valid, phase_out, energy_out, last_out, saturated, input ready);
    modport sink   (input valid, phase_out, energy_out, last_out, saturated, output ready);
endinterface

// ===== hdl/pkdt_drift.sv =====
module pkdt_drift
    import pkdt_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic                      active,
    input  logic                      subtract,
    input  logic signed [DRIFT_W-1:0] factor,
    input  item_t                     item_in,
    output item_t                     item_out
);

    localparam logic [56:0] RND_HALF = 57'd34359738368;  // 2^35

    item_t                st1_item_reg, st2_item_reg, st3_item_reg, out_reg;
    logic [ENERGY_W-1:0]  e_mag_reg;
    logic [DRIFT_W-1:0]   f_mag_reg;
    logic                 neg1_reg, neg2_reg;
    logic [55:0]          p_lo_reg, p_hi_reg;
    logic signed [45:0]   d_reg;

    logic [ENERGY_W-1:0]  e_mag_next;
    logic [DRIFT_W-1:0]   f_mag_next;
    logic [55:0]          p_lo_next, p_hi_next;
    logic [56:0]          rnd_sum, acc;
    logic [44:0]          m_mag;
    logic signed [45:0]   d_next;
    logic signed [46:0]   wide;
    logic                 ovf;
    item_t                out_next;

    // magnitudes and sign
    assign e_mag_next = item_in.energy[ENERGY_W-1] ? ENERGY_W'(-item_in.energy)
                                                   : ENERGY_W'(item_in.energy);
    assign f_mag_next = factor[DRIFT_W-1] ? DRIFT_W'(-factor) : DRIFT_W'(factor);

    // two 24-bit partial products
    assign p_lo_next = 56'(f_mag_reg) * 56'(e_mag_reg[23:0]);
    assign p_hi_next = 56'(f_mag_reg) * 56'(e_mag_reg[47:24]);

    // recombine, round half away from zero by 2^-36
    assign rnd_sum = 57'(p_lo_reg) + RND_HALF;
    assign acc     = 57'(p_hi_reg) + (rnd_sum >> 24);
    assign m_mag   = acc[56:12];
    assign d_next  = neg2_reg ? -$signed({1'b0, m_mag}) : $signed({1'b0, m_mag});

    // apply and saturate
    assign wide = subtract ? 47'(st3_item_reg.phase) - 47'(d_reg)
                           : 47'(st3_item_reg.phase) + 47'(d_reg);
    assign ovf  = wide[46:31] != {16{wide[46]}};

    always_comb
    begin
        out_next = st3_item_reg;
        if (active)
        begin
            if (ovf)
            begin
                out_next.phase = wide[46] ? {1'b1, {(PHASE_W-1){1'b0}}}
                                          : {1'b0, {(PHASE_W-1){1'b1}}};
            end
            else
            begin
                out_next.phase = wide[PHASE_W-1:0];
            end
            out_next.clip = st3_item_reg.clip | ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_item_reg <= item_in;
            e_mag_reg    <= e_mag_next;
            f_mag_reg    <= f_mag_next;
            neg1_reg     <= item_in.energy[ENERGY_W-1] ^ factor[DRIFT_W-1];
            st2_item_reg <= st1_item_reg;
            p_lo_reg     <= p_lo_next;
            p_hi_reg     <= p_hi_next;
            neg2_reg     <= neg1_reg;
            st3_item_reg <= st2_item_reg;
            d_reg        <= d_next;
            out_reg      <= out_next;
        end
    end

    assign item_out = out_reg;

endmodule

// ===== hdl/pkdt_sine.sv =====
module pkdt_sine
    import pkdt_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ANG_W-1:0] ang,
    output logic [30:0]             sin_mag,
    output logic                    sin_neg
);

    logic [ANG_W:0] u1_reg, u2_reg;
    logic [30:0]    r3_reg;
    logic [30:0]    x4_reg, x5_reg;
    logic           neg4_reg, neg5_reg;
    logic [31:0]    x2_5_reg;
    logic [30:0]    mag_reg;
    logic           neg_reg;

    logic [ANG_W:0] u1_next, u2_next, u3_v;
    logic [30:0]    fold_r, x4_next;
    logic           neg4_next;
    logic [61:0]    sq_prod, fin_prod;

    // Taylor chain, three stages per term
    logic [30:0] ch_t  [TAYLOR_N+1];
    logic [31:0] ch_x2 [TAYLOR_N+1];
    logic [30:0] ch_x  [TAYLOR_N+1];
    logic        ch_neg[TAYLOR_N+1];

    // shift to non-negative
    assign u1_next = ANG_W'(0) + {ang[ANG_W-1], ang} + ANG_OFFSET;

    // restoring reduction, upper four steps
    always_comb
    begin
        u2_next = u1_reg;
        for (int k = 7; k >= 4; k--)
        begin
            if (u2_next >= ((ANG_W+1)'(TWO_PI_Q28) << k))
                u2_next = u2_next - ((ANG_W+1)'(TWO_PI_Q28) << k);
        end
    end

    // lower four steps
    always_comb
    begin
        u3_v = u2_reg;
        for (int k = 3; k >= 0; k--)
        begin
            if (u3_v >= ((ANG_W+1)'(TWO_PI_Q28) << k))
                u3_v = u3_v - ((ANG_W+1)'(TWO_PI_Q28) << k);
        end
    end

    // fold into the first quadrant
    always_comb
    begin
        fold_r    = r3_reg;
        neg4_next = 1'b0;
        if (fold_r >= PI_Q28)
        begin
            fold_r    = fold_r - PI_Q28;
            neg4_next = 1'b1;
        end
        if (fold_r > HALF_PI_Q28)
            fold_r = PI_Q28 - fold_r;
        x4_next = {fold_r[28:0], 2'b00};
    end

    assign sq_prod = 62'(x4_reg) * 62'(x4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg   <= u1_next;
            u2_reg   <= u2_next;
            r3_reg   <= 31'(u3_v);
            x4_reg   <= x4_next;
            neg4_reg <= neg4_next;
            x5_reg   <= x4_reg;
            neg5_reg <= neg4_reg;
            x2_5_reg <= sq_prod[61:30];
        end
    end

    assign ch_t[0]   = ONE_Q30;
    assign ch_x2[0]  = x2_5_reg;
    assign ch_x[0]   = x5_reg;
    assign ch_neg[0] = neg5_reg;

    for (genvar i = 0; i < TAYLOR_N; i++)
    begin : g_term
        logic [31:0] a_p_reg, b_p_reg;
        logic [31:0] a_x2_reg, b_x2_reg, c_x2_reg;
        logic [30:0] a_x_reg, b_x_reg, c_x_reg;
        logic        a_neg_reg, b_neg_reg, c_neg_reg;
        logic [29:0] b_q0_reg;
        logic [30:0] c_t_reg;
        logic [62:0] a_prod;
        logic [61:0] b_prod;
        logic [37:0] qk;
        logic [31:0] rem;
        logic [29:0] q;

        // x2*t scaled back to Q.30
        assign a_prod = 63'(ch_x2[i]) * 63'(ch_t[i]);
        // quotient estimate, low by at most one
        assign b_prod = 62'(a_p_reg) * 62'(TAYLOR_RECIP[i]);
        // correct the estimate
        assign qk  = 38'(b_q0_reg) * 38'(TAYLOR_DIV[i]);
        assign rem = b_p_reg - qk[31:0];
        assign q   = (rem >= 32'(TAYLOR_DIV[i])) ? b_q0_reg + 30'd1 : b_q0_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_p_reg   <= a_prod[61:30];
                a_x2_reg  <= ch_x2[i];
                a_x_reg   <= ch_x[i];
                a_neg_reg <= ch_neg[i];
                b_p_reg   <= a_p_reg;
                b_q0_reg  <= b_prod[61:32];
                b_x2_reg  <= a_x2_reg;
                b_x_reg   <= a_x_reg;
                b_neg_reg <= a_neg_reg;
                c_t_reg   <= ONE_Q30 - 31'(q);
                c_x2_reg  <= b_x2_reg;
                c_x_reg   <= b_x_reg;
                c_neg_reg <= b_neg_reg;
            end
        end

        assign ch_t[i+1]   = c_t_reg;
        assign ch_x2[i+1]  = c_x2_reg;
        assign ch_x[i+1]   = c_x_reg;
        assign ch_neg[i+1] = c_neg_reg;
    end

    // final x*t
    assign fin_prod = 62'(ch_x[TAYLOR_N]) * 62'(ch_t[TAYLOR_N]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= fin_prod[60:30];
            neg_reg <= ch_neg[TAYLOR_N];
        end
    end

    assign sin_mag = mag_reg;
    assign sin_neg = neg_reg;

endmodule

// ===== hdl/pkdt_kick.sv =====
module pkdt_kick
    import pkdt_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  cfg_t                      cfg,
    input  logic signed [PHASE_W-1:0] phase,
    output logic signed [KICK_W-1:0]  kick
);

    logic signed [32:0]       arg1_1_reg, arg1_2_reg;
    logic signed [33:0]       y_1_reg;
    logic signed [50:0]       m_2_reg;
    logic signed [ANG_W-1:0]  arg1_3_reg, arg2_3_reg;
    logic [ENERGY_W-1:0]      am1_reg, am2_reg;
    logic                     an1_reg, an2_reg;
    logic [54:0]              lo1_reg, hi1_reg, lo2_reg, hi2_reg;
    logic                     kn1_reg, kn2_reg;
    logic signed [48:0]       k1_reg, k2_reg;
    logic signed [KICK_W-1:0] kick_reg;

    logic signed [50:0]       m_2_next, rnd2;
    logic [30:0]              s1_mag, s2_mag;
    logic                     s1_neg, s2_neg;
    logic signed [48:0]       k1_next, k2_next;

    // second harmonic angle
    assign m_2_next = 51'(y_1_reg) * 51'($signed({1'b0, cfg.harmonic_ratio}));
    assign rnd2     = m_2_reg + 51'sd2048;

    pkdt_sine u_sine_main
    (
        .clk     (clk),
        .en      (en),
        .ang     (arg1_3_reg),
        .sin_mag (s1_mag),
        .sin_neg (s1_neg)
    );

    pkdt_sine u_sine_second
    (
        .clk     (clk),
        .en      (en),
        .ang     (arg2_3_reg),
        .sin_mag (s2_mag),
        .sin_neg (s2_neg)
    );

    // round by 2^-30, half away from zero
    function automatic logic signed [48:0] amp_round(logic [54:0] lo, logic [54:0] hi,
                                                     logic neg);
        logic [55:0] t;
        logic [55:0] s;
        logic [48:0] m;
        t = 56'(lo) + 56'd536870912;
        s = 56'(hi) + (t >> 24);
        m = s[54:6];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    assign k1_next = amp_round(lo1_reg, hi1_reg, kn1_reg);
    assign k2_next = amp_round(lo2_reg, hi2_reg, kn2_reg);

    // amplitude magnitudes follow the registers
    always_ff @(posedge clk)
    begin
        am1_reg <= cfg.rf_amp_main[ENERGY_W-1] ? ENERGY_W'(-cfg.rf_amp_main)
                                               : ENERGY_W'(cfg.rf_amp_main);
        an1_reg <= cfg.rf_amp_main[ENERGY_W-1];
        am2_reg <= cfg.rf_amp_second[ENERGY_W-1] ? ENERGY_W'(-cfg.rf_amp_second)
                                                 : ENERGY_W'(cfg.rf_amp_second);
        an2_reg <= cfg.rf_amp_second[ENERGY_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arg1_1_reg <= 33'(phase) + 33'(cfg.sync_phase);
            y_1_reg    <= 34'(phase) + 34'(cfg.sync_phase) - 34'(cfg.harmonic_phase_shift);
            arg1_2_reg <= arg1_1_reg;
            m_2_reg    <= m_2_next;
            arg1_3_reg <= ANG_W'(arg1_2_reg);
            arg2_3_reg <= ANG_W'(rnd2 >>> 12);
            lo1_reg    <= 55'(s1_mag) * 55'(am1_reg[23:0]);
            hi1_reg    <= 55'(s1_mag) * 55'(am1_reg[47:24]);
            kn1_reg    <= s1_neg ^ an1_reg;
            lo2_reg    <= 55'(s2_mag) * 55'(am2_reg[23:0]);
            hi2_reg    <= 55'(s2_mag) * 55'(am2_reg[47:24]);
            kn2_reg    <= s2_neg ^ an2_reg;
            k1_reg     <= k1_next;
            k2_reg     <= k2_next;
            kick_reg   <= KICK_W'(k1_reg) + KICK_W'(k2_reg) - KICK_W'(cfg.energy_gain);
        end
    end

    assign kick = kick_reg;

endmodule

// ===== hdl/particle_kick_drift_turn_top.sv =====
// One machine turn of longitudinal tracking for a stream of particles with a
// dual-harmonic RF kick. A particle is taken every cycle unless the output
// stalls, and particles come out in order; the depth is set mostly by the
// sine unit, which spends three stages on each of its six polynomial terms.
// A stalled output freezes the whole pipeline, so nothing is dropped or
// repeated. Write the registers only while the pipeline is empty.
`include "particle_kick_drift_turn_top_assert.svh"

module particle_kick_drift_turn_top
    import pkdt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    pkdt_in_if.sink               ingress,
    pkdt_out_if.source            egress,
    input  logic                  wr_en,
    input  logic [REG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    cfg_t                     cfg_reg;
    logic [PIPE_LAT-1:0]      vld_reg;
    item_t                    side_reg [KICK_LAT];
    item_t                    apply_reg;

    logic                     adv;
    item_t                    item0, pre_out, post_out, apply_next;
    logic signed [KICK_W-1:0] kick;
    logic signed [51:0]       e_wide;
    logic                     e_ovf;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_RF_AMP_MAIN:   cfg_reg.rf_amp_main          <= wr_data;
                REG_RF_AMP_SECOND: cfg_reg.rf_amp_second        <= wr_data;
                REG_SYNC_PHASE:    cfg_reg.sync_phase           <= wr_data[PHASE_W-1:0];
                REG_HARM_SHIFT:    cfg_reg.harmonic_phase_shift <= wr_data[PHASE_W-1:0];
                REG_HARM_RATIO:    cfg_reg.harmonic_ratio       <= wr_data[HRATIO_W-1:0];
                REG_ENERGY_GAIN:   cfg_reg.energy_gain          <= wr_data;
                REG_DRIFT_FACTOR:  cfg_reg.drift_factor         <= wr_data[DRIFT_W-1:0];
                REG_DIRECTION:     cfg_reg.direction            <= wr_data[0];
            endcase
        end
    end

    // pipeline advances unless the output holds a result not yet taken
    assign adv           = !vld_reg[PIPE_LAT-1] || egress.ready;
    assign ingress.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_LAT-2:0], ingress.valid};
    end

    always_comb
    begin
        item0.phase  = ingress.phase_in;
        item0.energy = ingress.energy_in;
        item0.last   = ingress.last_in;
        item0.clip   = 1'b0;
    end

    // forward drift
    pkdt_drift u_drift_pre
    (
        .clk      (clk),
        .en       (adv),
        .active   (!cfg_reg.direction),
        .subtract (1'b1),
        .factor   (cfg_reg.drift_factor),
        .item_in  (item0),
        .item_out (pre_out)
    );

    pkdt_kick u_kick
    (
        .clk   (clk),
        .en    (adv),
        .cfg   (cfg_reg),
        .phase (pre_out.phase),
        .kick  (kick)
    );

    // particle waits alongside the kick
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= pre_out;
            for (int i = 1; i < KICK_LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // energy update with saturation
    assign e_wide = cfg_reg.direction ? 52'(side_reg[KICK_LAT-1].energy) - 52'(kick)
                                      : 52'(side_reg[KICK_LAT-1].energy) + 52'(kick);
    assign e_ovf  = e_wide[51:47] != {5{e_wide[51]}};

    always_comb
    begin
        apply_next      = side_reg[KICK_LAT-1];
        apply_next.clip = side_reg[KICK_LAT-1].clip | e_ovf;
        if (e_ovf)
            apply_next.energy = e_wide[51] ? {1'b1, {(ENERGY_W-1){1'b0}}}
                                           : {1'b0, {(ENERGY_W-1){1'b1}}};
        else
            apply_next.energy = e_wide[ENERGY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            apply_reg <= apply_next;
    end

    // backward drift
    pkdt_drift u_drift_post
    (
        .clk      (clk),
        .en       (adv),
        .active   (cfg_reg.direction),
        .subtract (1'b0),
        .factor   (cfg_reg.drift_factor),
        .item_in  (apply_reg),
        .item_out (post_out)
    );

    assign egress.valid      = vld_reg[PIPE_LAT-1];
    assign egress.phase_out  = post_out.phase;
    assign egress.energy_out = post_out.energy;
    assign egress.last_out   = post_out.last;
    assign egress.saturated  = post_out.clip;

    `PKDT_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld_reg), "valid bits moved during a stall")
    `PKDT_ASSERT_NEXT(a_accept_enters, ingress.valid && ingress.ready, vld_reg[0], "accepted request lost")
    `PKDT_ASSERT_NEXT(a_bubble_enters, adv && !ingress.valid, !vld_reg[0], "request invented")
    `PKDT_ASSERT_SAME(a_ready_follows, egress.valid, ingress.ready == egress.ready, "ready not tied to output")

endmodule

// ===== tb/sv/tb_particle_kick_drift_turn_top.sv =====
module tb_particle_kick_drift_turn_top;
    import pkdt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TURN_PI      = 843314857;
    localparam longint TURN_TWO_PI  = 1686629713;
    localparam longint TURN_HALF_PI = 421657428;
    localparam longint UNIT_Q30     = 64'd1073741824;
    localparam int     CYCLE_LIMIT  = 300000;
    localparam int     DRAIN_WAIT   = PIPE_LAT + 10;

    logic clk;
    logic rst_n;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    pkdt_in_if  ingress_bus ();
    pkdt_out_if egress_bus ();

    particle_kick_drift_turn_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .ingress  (ingress_bus),
        .egress   (egress_bus),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // register shadow used by the turn predictor
    cfg_t   shadow_cfg;
    item_t  particles_pending [$];
    item_t  turns_expected [$];
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_go;
    bit     hold_done;
    int     hold_left;
    int     cycle_count;
    int     error_count;
    int     requests_sent;
    int     turns_checked;
    int     clipped_turns;
    int     config_sets;

    // clock and reset
    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        ingress_bus.valid = 1'b0;
        ingress_bus.phase_in = '0;
        ingress_bus.energy_in = '0;
        ingress_bus.last_in = 1'b0;
        egress_bus.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // round(big*sm / 2^s), half away from zero
    function automatic longint mul_round_away(longint big, longint sm, int s);
        logic signed [95:0] prod;
        logic [95:0] mag;
        prod = 96'(signed'(big)) * 96'(signed'(sm));
        mag = prod < 0 ? -prod : prod;
        mag = (mag + (96'd1 << (s - 1))) >> s;
        return prod < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    // sine in Q.30 of a Q.28 angle, reduced modulo two pi
    function automatic longint sine_q30(longint ang);
        longint r;
        bit neg;
        longint unsigned x, x2, t;
        int divs [6];
        divs = '{156, 110, 72, 42, 20, 6};
        neg = 1'b0;
        r = ang % TURN_TWO_PI;
        if (r < 0)
            r += TURN_TWO_PI;
        if (r >= TURN_PI)
        begin
            r -= TURN_PI;
            neg = 1'b1;
        end
        if (r > TURN_HALF_PI)
            r = TURN_PI - r;
        x = longint'(r) << 2;
        x2 = (x * x) >> 30;
        t = UNIT_Q30;
        for (int i = 0; i < 6; i++)
            t = UNIT_Q30 - ((x2 * t) >> 30) / divs[i];
        t = (x * t) >> 30;
        return neg ? -longint'(t) : longint'(t);
    endfunction

    function automatic longint clamp(longint v, int w, inout bit clip);
        longint hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            clip = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            clip = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic longint rf_kick(longint ph);
        longint y, arg2;
        y = ph + longint'(shadow_cfg.sync_phase) - longint'(shadow_cfg.harmonic_phase_shift);
        arg2 = (y * longint'({1'b0, shadow_cfg.harmonic_ratio}) + 2048) >>> 12;
        return mul_round_away(shadow_cfg.rf_amp_main,
                              sine_q30(ph + longint'(shadow_cfg.sync_phase)), 30)
             + mul_round_away(shadow_cfg.rf_amp_second, sine_q30(arg2), 30)
             - longint'(shadow_cfg.energy_gain);
    endfunction

    // one machine turn of a particle
    function automatic item_t turn_particle(item_t p);
        item_t r;
        longint ph, en;
        bit clip;
        clip = 1'b0;
        ph = p.phase;
        en = p.energy;
        if (!shadow_cfg.direction)
        begin
            ph = clamp(ph - mul_round_away(en, shadow_cfg.drift_factor, 36), PHASE_W, clip);
            en = clamp(en + rf_kick(ph), ENERGY_W, clip);
        end
        else
        begin
            en = clamp(en - rf_kick(ph), ENERGY_W, clip);
            ph = clamp(ph + mul_round_away(en, shadow_cfg.drift_factor, 36), PHASE_W, clip);
        end
        r.phase = ph[PHASE_W-1:0];
        r.energy = en[ENERGY_W-1:0];
        r.last = p.last;
        r.clip = clip;
        return r;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (rst_n && (!ingress_bus.valid || ingress_bus.ready))
        begin
            if (particles_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item_t nxt;
                nxt = particles_pending.pop_front();
                ingress_bus.phase_in <= nxt.phase;
                ingress_bus.energy_in <= nxt.energy;
                ingress_bus.last_in <= nxt.last;
                ingress_bus.valid <= 1'b1;
            end
            else
                ingress_bus.valid <= 1'b0;
        end
    end

    // long hold-off of the receiver
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            egress_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // predict on each accepted request
    always @(posedge clk)
    begin
        if (rst_n && ingress_bus.valid && ingress_bus.ready)
        begin
            item_t p;
            p.phase = ingress_bus.phase_in;
            p.energy = ingress_bus.energy_in;
            p.last = ingress_bus.last_in;
            p.clip = 1'b0;
            turns_expected.push_back(turn_particle(p));
            requests_sent++;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && egress_bus.valid && egress_bus.ready)
        begin
            item_t e;
            if (turns_expected.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                e = turns_expected.pop_front();
                turns_checked++;
                if (e.clip)
                    clipped_turns++;
                if (egress_bus.phase_out !== e.phase)
                begin
                    $error("phase_out: expected %0d, got %0d", e.phase, egress_bus.phase_out);
                    error_count++;
                end
                if (egress_bus.energy_out !== e.energy)
                begin
                    $error("energy_out: expected %0d, got %0d", e.energy,
                           egress_bus.energy_out);
                    error_count++;
                end
                if (egress_bus.last_out !== e.last)
                begin
                    $error("last_out: expected %0b, got %0b", e.last, egress_bus.last_out);
                    error_count++;
                end
                if (egress_bus.saturated !== e.clip)
                begin
                    $error("saturated: expected %0b, got %0b", e.clip, egress_bus.saturated);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        case (idx)
            REG_RF_AMP_MAIN:   shadow_cfg.rf_amp_main = val;
            REG_RF_AMP_SECOND: shadow_cfg.rf_amp_second = val;
            REG_SYNC_PHASE:    shadow_cfg.sync_phase = val[PHASE_W-1:0];
            REG_HARM_SHIFT:    shadow_cfg.harmonic_phase_shift = val[PHASE_W-1:0];
            REG_HARM_RATIO:    shadow_cfg.harmonic_ratio = val[HRATIO_W-1:0];
            REG_ENERGY_GAIN:   shadow_cfg.energy_gain = val;
            REG_DRIFT_FACTOR:  shadow_cfg.drift_factor = val[DRIFT_W-1:0];
            default:           shadow_cfg.direction = val[0];
        endcase
    endtask

    task automatic load_config(cfg_t c);
        write_reg(REG_RF_AMP_MAIN, c.rf_amp_main);
        write_reg(REG_RF_AMP_SECOND, c.rf_amp_second);
        write_reg(REG_SYNC_PHASE, CFG_DATA_W'(c.sync_phase));
        write_reg(REG_HARM_SHIFT, CFG_DATA_W'(c.harmonic_phase_shift));
        write_reg(REG_HARM_RATIO, CFG_DATA_W'(c.harmonic_ratio));
        write_reg(REG_ENERGY_GAIN, c.energy_gain);
        write_reg(REG_DRIFT_FACTOR, CFG_DATA_W'(c.drift_factor));
        write_reg(REG_DIRECTION, CFG_DATA_W'(c.direction));
        @(posedge clk);
        wr_en <= 1'b0;
        config_sets++;
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // mostly physical particles, some full-range noise
    function automatic item_t rand_particle();
        item_t p;
        int k;
        k = $urandom_range(9);
        p.last = $urandom_range(7) == 0;
        p.clip = 1'b0;
        if (k < 3)
        begin
            p.phase = $urandom;
            p.energy = rand48();
        end
        else
        begin
            p.phase = PHASE_W'(longint'($urandom_range(1686629713)) - 843314857);
            p.energy = ENERGY_W'(signed'(rand48()) >>> $urandom_range(47, 10));
        end
        return p;
    endfunction

    function automatic cfg_t rand_config(bit physical, bit dir);
        cfg_t c;
        c.rf_amp_main = rand48();
        c.rf_amp_second = rand48();
        c.sync_phase = $urandom;
        c.harmonic_phase_shift = $urandom;
        c.harmonic_ratio = HRATIO_W'($urandom);
        c.energy_gain = rand48();
        c.drift_factor = $urandom;
        if (physical)
        begin
            c.rf_amp_main = signed'(c.rf_amp_main) >>> 18;
            c.rf_amp_second = signed'(c.rf_amp_second) >>> 20;
            c.sync_phase = signed'(c.sync_phase) >>> 2;
            c.harmonic_ratio = 16'd8192;
            c.energy_gain = signed'(c.energy_gain) >>> 24;
            c.drift_factor = signed'(c.drift_factor) >>> 4;
        end
        c.direction = dir;
        return c;
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (particles_pending.size() > 0 || ingress_bus.valid || turns_expected.size() > 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic run_batch(int n, int idle, int stall);
        @(negedge clk);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) particles_pending.push_back(rand_particle());
        wait_drained();
    endtask

    task automatic push_particle(logic [31:0] ph, logic [47:0] en, bit lst);
        item_t p;
        p.phase = ph;
        p.energy = en;
        p.last = lst;
        p.clip = 1'b0;
        particles_pending.push_back(p);
    endtask

    task automatic directed_set();
        push_particle(32'h7fffffff, 48'h7fffffffffff, 1'b0);
        push_particle(32'h80000000, 48'h800000000000, 1'b1);
        push_particle(32'h80000000, 48'h7fffffffffff, 1'b0);
        push_particle(32'h7fffffff, 48'h800000000000, 1'b0);
        push_particle('0, '0, 1'b1);
        push_particle(32'(TURN_PI), 48'h10000, 1'b0);
        push_particle(32'(-TURN_PI), -48'sh10000, 1'b0);
        push_particle(32'(TURN_HALF_PI), 48'h1, 1'b0);
        push_particle(32'(TURN_HALF_PI + 1), 48'hffffffffffff, 1'b0);
        push_particle(32'(TURN_TWO_PI), 48'h0, 1'b0);
        push_particle(32'hffffffff, 48'h555555555555, 1'b1);
        push_particle(32'h55555555, 48'haaaaaaaaaaaa, 1'b0);
    endtask

    // phase sequence
    initial
    begin
        cfg_t c;
        shadow_cfg = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_go = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        cycle_count = 0;
        error_count = 0;
        requests_sent = 0;
        turns_checked = 0;
        clipped_turns = 0;
        config_sets = 0;
        @(posedge rst_n);

        // reset registers, then directed particles under several settings
        directed_set();
        wait_drained();
        c = rand_config(1'b1, 1'b0);
        load_config(c);
        directed_set();
        wait_drained();
        c.direction = 1'b1;
        load_config(c);
        directed_set();
        wait_drained();

        // all-maximum and all-minimum registers
        c = '{48'h7fffffffffff, 48'h7fffffffffff, 32'h7fffffff, 32'h7fffffff,
              16'hffff, 48'h7fffffffffff, 32'h7fffffff, 1'b0};
        load_config(c);
        run_batch(100, 0, 0);
        c = '{48'h800000000000, 48'h800000000000, 32'h80000000, 32'h80000000,
              16'h0000, 48'h800000000000, 32'h80000000, 1'b1};
        load_config(c);
        run_batch(100, 50, 0);

        // physical settings under each idling pattern
        load_config(rand_config(1'b1, 1'b0));
        run_batch(150, 0, 0);
        load_config(rand_config(1'b1, 1'b1));
        run_batch(150, 50, 0);
        load_config(rand_config(1'b1, 1'b0));
        run_batch(150, 0, 50);
        load_config(rand_config(1'b1, 1'b1));
        run_batch(150, 11, 11);

        // receiver held off while the sender keeps offering
        load_config(rand_config(1'b1, 1'b0));
        @(negedge clk);
        hold_go = 1'b1;
        run_batch(150, 0, 0);

        // full-range registers
        load_config(rand_config(1'b0, 1'b0));
        run_batch(150, 11, 11);
        load_config(rand_config(1'b0, 1'b1));
        run_batch(150, 50, 50);

        $display("Covered %0d particle requests over %0d register settings, both directions.",
                 requests_sent, config_sets);
        $display("%0d turns checked, %0d of them clipped.", turns_checked, clipped_turns);
        if (error_count == 0 && turns_expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
